// ===== src/input_activity_stats_logger_macros.svh =====
// Assertion macros shared by the activity logger RTL.
`ifndef INPUT_ACTIVITY_STATS_LOGGER_MACROS_SVH
`define INPUT_ACTIVITY_STATS_LOGGER_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define IASL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define IASL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/iasl_pkg.sv =====
// Types, codes and constants of the input activity statistics logger.
package iasl_pkg;

	localparam int HISTORY_DEPTH_DEF = 64;
	localparam int BUTTON_COUNT_DEF  = 32;
	localparam int RATE_W            = 10;
	localparam int RATE_NUM          = 1000;
	localparam int GAP_LIMIT         = 1000;
	localparam int DIV_CNT_W         = 4;

	typedef enum logic [1:0] {
		KIND_RECORD     = 2'd0,
		KIND_CLEAR      = 2'd1,
		KIND_READ_PRESS = 2'd2,
		KIND_READ_HIST  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EXEC = 2'd1,
		ST_DIV  = 2'd2,
		ST_RESP = 2'd3
	} state_t;

	typedef struct packed {
		kind_t              kind;
		logic [31:0]        now_ms;
		logic [31:0]        buttons;
		logic signed [15:0] left_x;
		logic signed [15:0] left_y;
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic [5:0]         read_index;
	} in_item_t;

	typedef struct packed {
		logic [9:0]         poll_rate;
		logic [31:0]        poll_total;
		logic [31:0]        logged_count;
		logic [5:0]         write_slot;
		logic [31:0]        press_count;
		logic [31:0]        entry_time;
		logic [31:0]        entry_buttons;
		logic signed [15:0] entry_left_x;
		logic signed [15:0] entry_left_y;
		logic signed [15:0] entry_right_x;
		logic signed [15:0] entry_right_y;
	} out_item_t;

	typedef struct packed {
		logic [31:0]        stamp;
		logic [31:0]        keys;
		logic signed [15:0] left_x;
		logic signed [15:0] left_y;
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
	} hist_entry_t;

	localparam int ENTRY_W = $bits(hist_entry_t);

	typedef struct packed {
		logic load;
		logic exec;
		logic div_step;
		logic resp_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_need;
		logic div_last;
	} dp_stat_t;

endpackage

// ===== src/iasl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module iasl_ram #(
	parameter int WIDTH = iasl_pkg::ENTRY_W,
	parameter int DEPTH = iasl_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/iasl_ctrl.sv =====
// Sequencer: accept, execute, divide and respond phases of one transfer.
module iasl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  iasl_pkg::dp_stat_t  stat,
	output iasl_pkg::ctrl_cmd_t cmd,
	output logic                busy,
	output logic                done
);

	iasl_pkg::state_t state_q, state_next;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iasl_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			done_q  <= (state_q == iasl_pkg::ST_RESP);
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			iasl_pkg::ST_IDLE: begin
				if (start) begin
					state_next = iasl_pkg::ST_EXEC;
				end
			end
			iasl_pkg::ST_EXEC: begin
				state_next = stat.div_need ? iasl_pkg::ST_DIV : iasl_pkg::ST_RESP;
			end
			iasl_pkg::ST_DIV: begin
				if (stat.div_last) begin
					state_next = iasl_pkg::ST_RESP;
				end
			end
			iasl_pkg::ST_RESP: begin
				state_next = iasl_pkg::ST_IDLE;
			end
			default: begin
				state_next = iasl_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			iasl_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			iasl_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			iasl_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			iasl_pkg::ST_RESP: begin
				cmd.resp_load = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	assign done = done_q;

endmodule

// ===== src/iasl_dp.sv =====
// Datapath: statistics registers, press counters, history RAM, rate divider.
module iasl_dp #(
	parameter int HISTORY_DEPTH = iasl_pkg::HISTORY_DEPTH_DEF,
	parameter int BUTTON_COUNT  = iasl_pkg::BUTTON_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  iasl_pkg::in_item_t  item,
	input  iasl_pkg::ctrl_cmd_t cmd,
	output iasl_pkg::dp_stat_t  stat,
	output iasl_pkg::out_item_t result
);

	localparam int AW  = $clog2(HISTORY_DEPTH);
	localparam int BIW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
	localparam int RW  = iasl_pkg::RATE_W;
	localparam int CW  = iasl_pkg::DIV_CNT_W;
	localparam int ENTRY_BITS = iasl_pkg::ENTRY_W;

	iasl_pkg::in_item_t  item_q;
	iasl_pkg::out_item_t out_q, out_next;
	iasl_pkg::hist_entry_t wr_entry, rd_entry;

	logic [31:0]   prev_buttons_q;
	logic [31:0]   prev_time_q;
	logic [RW-1:0] rate_q;
	logic [31:0]   sample_total_q;
	logic [31:0]   press_q [BUTTON_COUNT];
	logic [AW-1:0] pos_q, pos_next;
	logic [31:0]   hist_total_q;
	logic [31:0]   last_keys_q;

	// restoring divider for 1000 / gap
	logic [RW-1:0] rem_q, dvd_q, quo_q, divisor_q;
	logic [CW-1:0] div_cnt_q;
	logic [RW:0]   trial, diff;
	logic          ge;
	logic [RW-1:0] quo_next;

	logic [31:0]   gap, rises;
	logic          is_rec, is_clr, append, ram_we, ram_re;
	logic [ENTRY_BITS-1:0] ram_rdata;
	logic          press_ok, hist_ok;

	assign is_rec = cmd.exec && (item_q.kind == iasl_pkg::KIND_RECORD);
	assign is_clr = cmd.exec && (item_q.kind == iasl_pkg::KIND_CLEAR);
	assign gap    = item_q.now_ms - prev_time_q;
	assign rises  = item_q.buttons & ~prev_buttons_q;
	assign append = (hist_total_q == 32'd0) || (item_q.buttons != last_keys_q);
	assign pos_next = (pos_q == AW'(HISTORY_DEPTH - 1)) ? '0 : pos_q + AW'(1);

	assign stat.div_need = (item_q.kind == iasl_pkg::KIND_RECORD) && (prev_time_q != 32'd0)
		&& (gap != 32'd0) && (gap < 32'(iasl_pkg::GAP_LIMIT));
	assign stat.div_last = (div_cnt_q == CW'(RW - 1));

	assign trial    = {rem_q, dvd_q[RW-1]};
	assign ge       = (trial >= {1'b0, divisor_q});
	assign diff     = trial - {1'b0, divisor_q};
	assign quo_next = {quo_q[RW-2:0], ge};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.exec) begin
			rem_q     <= '0;
			dvd_q     <= RW'(iasl_pkg::RATE_NUM);
			quo_q     <= '0;
			divisor_q <= gap[RW-1:0];
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= ge ? diff[RW-1:0] : trial[RW-1:0];
			dvd_q     <= {dvd_q[RW-2:0], 1'b0};
			quo_q     <= quo_next;
			div_cnt_q <= div_cnt_q + CW'(1);
		end
		if (cmd.resp_load) begin
			out_q <= out_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_buttons_q <= '0;
			prev_time_q    <= '0;
			rate_q         <= '0;
			sample_total_q <= '0;
			pos_q          <= '0;
			hist_total_q   <= '0;
			last_keys_q    <= '0;
		end else begin
			if (is_rec) begin
				prev_buttons_q <= item_q.buttons;
				prev_time_q    <= item_q.now_ms;
				sample_total_q <= sample_total_q + 32'd1;
				if (append) begin
					pos_q        <= pos_next;
					hist_total_q <= hist_total_q + 32'd1;
					last_keys_q  <= item_q.buttons;
				end
			end else if (is_clr) begin
				sample_total_q <= '0;
				pos_q          <= '0;
				hist_total_q   <= '0;
			end
			if (cmd.div_step && stat.div_last) begin
				rate_q <= quo_next;
			end
		end
	end

	for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_press
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				press_q[b] <= '0;
			end else if (is_clr) begin
				press_q[b] <= '0;
			end else if (is_rec && rises[b]) begin
				press_q[b] <= press_q[b] + 32'd1;
			end
		end
	end

	always_comb begin
		wr_entry.stamp   = item_q.now_ms;
		wr_entry.keys    = item_q.buttons;
		wr_entry.left_x  = item_q.left_x;
		wr_entry.left_y  = item_q.left_y;
		wr_entry.right_x = item_q.right_x;
		wr_entry.right_y = item_q.right_y;
	end

	assign ram_we = is_rec && append;
	assign ram_re = cmd.exec && (item_q.kind == iasl_pkg::KIND_READ_HIST);

	iasl_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (HISTORY_DEPTH)
	) u_hist_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos_q),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (AW'(item_q.read_index)),
		.rdata (ram_rdata)
	);

	assign rd_entry = iasl_pkg::hist_entry_t'(ram_rdata);
	assign press_ok = (item_q.kind == iasl_pkg::KIND_READ_PRESS)
		&& ({26'd0, item_q.read_index} < 32'(BUTTON_COUNT));
	assign hist_ok  = (item_q.kind == iasl_pkg::KIND_READ_HIST)
		&& ({26'd0, item_q.read_index} < 32'(HISTORY_DEPTH));

	always_comb begin
		out_next              = '0;
		out_next.poll_rate    = rate_q;
		out_next.poll_total   = sample_total_q;
		out_next.logged_count = hist_total_q;
		out_next.write_slot   = 6'(pos_q);
		if (press_ok) begin
			out_next.press_count = press_q[item_q.read_index[BIW-1:0]];
		end
		if (hist_ok) begin
			out_next.entry_time    = rd_entry.stamp;
			out_next.entry_buttons = rd_entry.keys;
			out_next.entry_left_x  = rd_entry.left_x;
			out_next.entry_left_y  = rd_entry.left_y;
			out_next.entry_right_x = rd_entry.right_x;
			out_next.entry_right_y = rd_entry.right_y;
		end
	end

	assign result = out_q;

endmodule

// ===== src/input_activity_stats_logger.sv =====
// Top level of the input activity statistics logger.
//
//  channel   handshake      payload      transfer when
//  command   start / busy   item         start high and busy low at clk rise
//  result    done           result       done high at clk rise (one cycle)
//
// A transfer that needs no rate update passes through the execute and respond
// states before the next accept; a record with a gap of 1 to 999 ms also runs
// the ten-step restoring divider that forms 1000 / gap one quotient bit a cycle.
// One item is in flight at a time; busy is low only while idle.
// arst_n clears statistics, counters and control; history RAM is not cleared.
// Results cannot be stalled: done marks each result for exactly one cycle.
`include "input_activity_stats_logger_macros.svh"

module input_activity_stats_logger #(
	parameter int HISTORY_DEPTH = iasl_pkg::HISTORY_DEPTH_DEF,
	parameter int BUTTON_COUNT  = iasl_pkg::BUTTON_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  iasl_pkg::in_item_t  item,
	output logic                done,
	output iasl_pkg::out_item_t result
);

	iasl_pkg::ctrl_cmd_t cmd;
	iasl_pkg::dp_stat_t  stat;

	iasl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	iasl_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.BUTTON_COUNT  (BUTTON_COUNT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

	`IASL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transfer did not raise busy")
	`IASL_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still busy")
	`IASL_ASSERT_NEXT(a_div_to_resp, cmd.div_step && stat.div_last, cmd.resp_load, "divider end not followed by response")
	`IASL_ASSERT_NOW(a_rate_range, done, result.poll_rate <= 10'd1000, "poll rate above 1000")

endmodule
